FILE: hdl/rsh_pkg.sv
package rsh_pkg;

   // Number of uplink slots in one generated table.
   localparam int NumSlots = 20;

   // Gold sequence warm-up length and register width.
   localparam int GoldNc = 1600;
   localparam int GoldW  = 31;

   // Group and sequence hopping are reduced modulo this count.
   localparam int NumGroups = 30;

   // Field widths of the channels and registers.
   localparam int SlotW    = 5;
   localparam int GroupW   = 5;
   localparam int ByteW    = 8;
   localparam int CellW    = 9;
   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 9;

   // Seed of generator B is 32 * (cell_id / 30) plus the PUSCH sequence shift,
   // at most ten bits.
   localparam int SeedW = 10;

   // Dividend of the serial mod-30 unit.
   localparam int DivW = 9;

   // Width of the cycle counter used for warm-up, byte capture and skipping.
   localparam int CntW = 11;

   // Symbols per slot for the two cyclic prefix lengths.
   localparam int NsymbNormal   = 7;
   localparam int NsymbExtended = 6;

   // Register indices of the configuration port.
   localparam logic [CsrIdxW-1:0] RegCellId      = 3'd0;
   localparam logic [CsrIdxW-1:0] RegGroupOffset = 3'd1;
   localparam logic [CsrIdxW-1:0] RegGroupHopEn  = 3'd2;
   localparam logic [CsrIdxW-1:0] RegSeqHopEn    = 3'd3;
   localparam logic [CsrIdxW-1:0] RegExtendedCp  = 3'd4;

   typedef struct packed {
      logic start_req;
   } req_type;

   typedef struct packed {
      logic [SlotW-1:0]  slot_index;
      logic [GroupW-1:0] group_pusch;
      logic [GroupW-1:0] group_pucch;
      logic              seq_hop_bit;
      logic [ByteW-1:0]  prs_byte;
      logic              last;
   } rsp_type;

   // Status of the serial mod-30 unit; quot and rem hold once done is seen.
   typedef struct packed {
      logic             done;
      logic [DivW-1:0]  quot;
      logic [GroupW-1:0] rem;
   } mod_res_type;

endpackage

FILE: hdl/rsh_stream_if.sv
interface rsh_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/rsh_gold.sv
// One 3GPP Gold sequence generator, advanced one bit per enabled cycle.
module rsh_gold (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load_i,
   input  logic [rsh_pkg::SeedW-1:0] seed_i,
   input  logic                     step_i,
   output logic                     bit_o
);

   logic [rsh_pkg::GoldW-1:0] x1_ff, x1_in;
   logic [rsh_pkg::GoldW-1:0] x2_ff, x2_in;

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      if (load_i) begin
         x1_in = rsh_pkg::GoldW'(1);
         x2_in = rsh_pkg::GoldW'(seed_i);
      end else if (step_i) begin
         x1_in = {x1_ff[3] ^ x1_ff[0], x1_ff[rsh_pkg::GoldW-1:1]};
         x2_in = {x2_ff[3] ^ x2_ff[2] ^ x2_ff[1] ^ x2_ff[0], x2_ff[rsh_pkg::GoldW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
      end
   end

   assign bit_o = x1_ff[0] ^ x2_ff[0];

endmodule

FILE: hdl/rsh_mod30.sv
// Restoring division by 30, one dividend bit per cycle, most significant first.
module rsh_mod30 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start_i,
   input  logic [rsh_pkg::DivW-1:0]  dividend_i,
   output rsh_pkg::mod_res_type      res_o
);

   localparam int StepW = $clog2(rsh_pkg::DivW + 1);

   logic [rsh_pkg::DivW-1:0]   num_ff, num_in;
   logic [rsh_pkg::DivW-1:0]   quo_ff, quo_in;
   logic [rsh_pkg::GroupW-1:0] rem_ff, rem_in;
   logic [StepW-1:0]           cnt_ff, cnt_in;
   logic                       done_ff, done_in;
   logic [rsh_pkg::GroupW:0]   trial;
   logic                       fits;

   assign trial = {rem_ff, num_ff[rsh_pkg::DivW-1]};
   assign fits  = trial >= (rsh_pkg::GroupW+1)'(rsh_pkg::NumGroups);

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start_i) begin
         num_in = dividend_i;
         rem_in = '0;
         cnt_in = StepW'(rsh_pkg::DivW);
      end else if (cnt_ff != '0) begin
         num_in  = {num_ff[rsh_pkg::DivW-2:0], 1'b0};
         quo_in  = {quo_ff[rsh_pkg::DivW-2:0], fits};
         rem_in  = fits ? rsh_pkg::GroupW'(trial - (rsh_pkg::GroupW+1)'(rsh_pkg::NumGroups))
                        : trial[rsh_pkg::GroupW-1:0];
         cnt_in  = cnt_ff - StepW'(1);
         done_in = (cnt_ff == StepW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign res_o.done = done_ff;
   assign res_o.quot = quo_ff;
   assign res_o.rem  = rem_ff;

endmodule

FILE: hdl/ul_reference_signal_hopping_gen.sv
// Uplink reference-signal hopping table generator.
// A transfer on the request channel with start_req set produces NUM_SLOTS result
// transfers on the response channel, one per uplink slot in slot order, the last
// one flagged. A request with start_req clear is taken and produces nothing.
// Registers are written through the csr_ port and must only change while idle.
// Before the first result the block runs two serial mod-30 divisions, the
// bit-serial warm-up of both Gold generators, the byte capture and two further
// divisions. Before each further result generator B skips ahead, the next bytes
// are captured and two divisions reduce the group numbers.
// One request is handled at a time; the request channel is ready only when idle.
// If the receiver stalls, the generators freeze and the result waits unchanged.
// Reset is synchronous and clears the registers and the sequencer to idle.
module ul_reference_signal_hopping_gen #(
   parameter int NUM_SLOTS = rsh_pkg::NumSlots
) (
   input  logic                        clock,
   input  logic                        reset,
   rsh_stream_if.sink                  req_if,
   rsh_stream_if.source                rsp_if,
   input  logic                        csr_we,
   input  logic [rsh_pkg::CsrIdxW-1:0] csr_index,
   input  logic [rsh_pkg::CsrDataW-1:0] csr_wdata
);

   localparam int SlotIdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int SeqCntW  = $clog2(NUM_SLOTS + 1);
   localparam int CntW     = rsh_pkg::CntW;

   localparam logic [CntW-1:0] WarmLast    = CntW'(rsh_pkg::GoldNc - 1);
   localparam logic [CntW-1:0] ByteLast    = CntW'(rsh_pkg::ByteW - 1);
   localparam logic [CntW-1:0] SkipNormal  =
      CntW'(rsh_pkg::ByteW * (rsh_pkg::NsymbNormal - 1) - 1);
   localparam logic [CntW-1:0] SkipExtended =
      CntW'(rsh_pkg::ByteW * (rsh_pkg::NsymbExtended - 1) - 1);

   // Sequencer states.
   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DIV_CELL  = 9'b000000010,
      ST_DIV_PUSCH = 9'b000000100,
      ST_WARM      = 9'b000001000,
      ST_CAPTURE   = 9'b000010000,
      ST_RED_PUSCH = 9'b000100000,
      ST_RED_PUCCH = 9'b001000000,
      ST_OUT       = 9'b010000000,
      ST_SKIP      = 9'b100000000
   } state_type;

   // Configuration registers.
   logic [rsh_pkg::CellW-1:0]  cell_id_ff;
   logic [rsh_pkg::GroupW-1:0] group_offset_ff;
   logic                       group_hop_en_ff;
   logic                       seq_hop_en_ff;
   logic                       extended_cp_ff;

   // Sequencer and counters.
   state_type                  state_ff, state_in;
   logic [CntW-1:0]            cnt_ff, cnt_in;
   logic [rsh_pkg::SlotW-1:0]  slot_ff, slot_in;
   logic [SeqCntW-1:0]         seq_cnt_ff, seq_cnt_in;

   // Per-table and per-slot values.
   logic [rsh_pkg::GroupW-1:0] q_ff, q_in;
   logic [rsh_pkg::GroupW-1:0] pucch_shift_ff, pucch_shift_in;
   logic [rsh_pkg::GroupW-1:0] pusch_shift_ff, pusch_shift_in;
   logic [rsh_pkg::ByteW-1:0]  gh_ff, gh_in;
   logic [rsh_pkg::ByteW-1:0]  prs_ff, prs_in;
   logic [rsh_pkg::GroupW-1:0] grp_pusch_ff, grp_pusch_in;
   logic [rsh_pkg::GroupW-1:0] grp_pucch_ff, grp_pucch_in;
   logic [NUM_SLOTS-1:0]       seq_ff;

   // Links to the generators and the divider.
   logic                       gold_load;
   logic [rsh_pkg::SeedW-1:0]  seed_a, seed_b;
   logic                       step_a, step_b;
   logic                       bit_a, bit_b;
   logic                       mod_start;
   logic [rsh_pkg::DivW-1:0]   mod_dividend;
   rsh_pkg::mod_res_type       mod_res;
   logic                       seq_write;
   logic                       last_slot;

   rsh_gold u_gold_a (
      .clock  (clock),
      .reset  (reset),
      .load_i (gold_load),
      .seed_i (seed_a),
      .step_i (step_a),
      .bit_o  (bit_a)
   );

   rsh_gold u_gold_b (
      .clock  (clock),
      .reset  (reset),
      .load_i (gold_load),
      .seed_i (seed_b),
      .step_i (step_b),
      .bit_o  (bit_b)
   );

   rsh_mod30 u_mod30 (
      .clock      (clock),
      .reset      (reset),
      .start_i    (mod_start),
      .dividend_i (mod_dividend),
      .res_o      (mod_res)
   );

   // Configuration writes; unknown indices are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_id_ff      <= '0;
         group_offset_ff <= '0;
         group_hop_en_ff <= 1'b0;
         seq_hop_en_ff   <= 1'b0;
         extended_cp_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            rsh_pkg::RegCellId:      cell_id_ff      <= csr_wdata[rsh_pkg::CellW-1:0];
            rsh_pkg::RegGroupOffset: group_offset_ff <= csr_wdata[rsh_pkg::GroupW-1:0];
            rsh_pkg::RegGroupHopEn:  group_hop_en_ff <= csr_wdata[0];
            rsh_pkg::RegSeqHopEn:    seq_hop_en_ff   <= csr_wdata[0];
            rsh_pkg::RegExtendedCp:  extended_cp_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign last_slot = (slot_ff == rsh_pkg::SlotW'(NUM_SLOTS - 1));

   // Generator A is seeded with cell_id / 30, generator B with 32 * (cell_id / 30)
   // plus the PUSCH sequence shift; since that shift is below 32 it is a plain
   // concatenation.
   assign seed_a = rsh_pkg::SeedW'(q_ff);
   assign seed_b = {q_ff, mod_res.rem};

   // The first NUM_SLOTS bits of generator B after warm-up are the sequence
   // hopping bits; they always arrive before the slot that needs them.
   assign seq_write = (state_ff inside {ST_CAPTURE, ST_SKIP}) &&
                      (seq_cnt_ff < SeqCntW'(NUM_SLOTS));

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      slot_in        = slot_ff;
      seq_cnt_in     = seq_cnt_ff;
      q_in           = q_ff;
      pucch_shift_in = pucch_shift_ff;
      pusch_shift_in = pusch_shift_ff;
      gh_in          = gh_ff;
      prs_in         = prs_ff;
      grp_pusch_in   = grp_pusch_ff;
      grp_pucch_in   = grp_pucch_ff;
      gold_load      = 1'b0;
      step_a         = 1'b0;
      step_b         = 1'b0;
      mod_start      = 1'b0;
      mod_dividend   = rsh_pkg::DivW'(cell_id_ff);
      if (seq_write) begin
         seq_cnt_in = seq_cnt_ff + SeqCntW'(1);
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid && req_if.payload.start_req) begin
               mod_start = 1'b1;
               state_in  = ST_DIV_CELL;
            end
         end
         ST_DIV_CELL: begin
            if (mod_res.done) begin
               q_in           = mod_res.quot[rsh_pkg::GroupW-1:0];
               pucch_shift_in = mod_res.rem;
               mod_start      = 1'b1;
               mod_dividend   = rsh_pkg::DivW'(mod_res.rem) + rsh_pkg::DivW'(group_offset_ff);
               state_in       = ST_DIV_PUSCH;
            end
         end
         ST_DIV_PUSCH: begin
            if (mod_res.done) begin
               pusch_shift_in = mod_res.rem;
               gold_load      = 1'b1;
               cnt_in         = WarmLast;
               slot_in        = '0;
               seq_cnt_in     = '0;
               state_in       = ST_WARM;
            end
         end
         ST_WARM: begin
            step_a = 1'b1;
            step_b = 1'b1;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               cnt_in   = ByteLast;
               state_in = ST_CAPTURE;
            end
         end
         ST_CAPTURE: begin
            // Both bytes fill least significant bit first.
            step_a = 1'b1;
            step_b = 1'b1;
            gh_in  = {bit_a, gh_ff[rsh_pkg::ByteW-1:1]};
            prs_in = {bit_b, prs_ff[rsh_pkg::ByteW-1:1]};
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               mod_start    = 1'b1;
               mod_dividend = (group_hop_en_ff ? rsh_pkg::DivW'(gh_in) : '0) +
                              rsh_pkg::DivW'(pusch_shift_ff);
               state_in     = ST_RED_PUSCH;
            end
         end
         ST_RED_PUSCH: begin
            if (mod_res.done) begin
               grp_pusch_in = mod_res.rem;
               mod_start    = 1'b1;
               mod_dividend = (group_hop_en_ff ? rsh_pkg::DivW'(gh_ff) : '0) +
                              rsh_pkg::DivW'(pucch_shift_ff);
               state_in     = ST_RED_PUCCH;
            end
         end
         ST_RED_PUCCH: begin
            if (mod_res.done) begin
               grp_pucch_in = mod_res.rem;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_if.ready) begin
               if (last_slot) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + rsh_pkg::SlotW'(1);
                  cnt_in   = extended_cp_ff ? SkipExtended : SkipNormal;
                  state_in = ST_SKIP;
               end
            end
         end
         ST_SKIP: begin
            // Generator B runs over the bytes between two slots' PRS bytes.
            step_b = 1'b1;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               cnt_in   = ByteLast;
               state_in = ST_CAPTURE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         slot_ff    <= '0;
         seq_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         slot_ff    <= slot_in;
         seq_cnt_ff <= seq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff           <= q_in;
      pucch_shift_ff <= pucch_shift_in;
      pusch_shift_ff <= pusch_shift_in;
      gh_ff          <= gh_in;
      prs_ff         <= prs_in;
      grp_pusch_ff   <= grp_pusch_in;
      grp_pucch_ff   <= grp_pucch_in;
      if (seq_write) begin
         seq_ff[seq_cnt_ff[SlotIdxW-1:0]] <= bit_b;
      end
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign rsp_if.valid = (state_ff == ST_OUT);

   // Sequence hopping only applies with group hopping switched off.
   assign rsp_if.payload.slot_index  = slot_ff;
   assign rsp_if.payload.group_pusch = grp_pusch_ff;
   assign rsp_if.payload.group_pucch = grp_pucch_ff;
   assign rsp_if.payload.seq_hop_bit = !group_hop_en_ff && seq_hop_en_ff &&
                                       seq_ff[slot_ff[SlotIdxW-1:0]];
   assign rsp_if.payload.prs_byte    = prs_ff;
   assign rsp_if.payload.last        = last_slot;

endmodule

FILE: hdl/rsh_checker.sv
module rsh_checker #(
   parameter int NUM_SLOTS = rsh_pkg::NumSlots
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsh_pkg::rsp_type rsp_payload
);

   logic rsp_xfer;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // A stalled result stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or was withdrawn");

   // A new request is never taken while a result is on offer.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request channel ready while a result is pending");

   // Slot numbers stay in range and the flag marks the final slot only.
   a_slot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.slot_index < 5'(NUM_SLOTS)) &&
                    (rsp_payload.last == (rsp_payload.slot_index == 5'(NUM_SLOTS - 1))))
      else $error("slot index out of range or last flag misplaced");

   // Group numbers are reduced modulo 30.
   a_group_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.group_pusch < 5'(rsh_pkg::NumGroups)) &&
                    (rsp_payload.group_pucch < 5'(rsh_pkg::NumGroups)))
      else $error("group number not reduced");

   // After the final transfer the block is idle again.
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_payload.last |=> req_ready && !rsp_valid)
      else $error("block not idle after the final result");

endmodule

bind ul_reference_signal_hopping_gen rsh_checker #(
   .NUM_SLOTS (NUM_SLOTS)
) u_rsh_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_if.valid),
   .req_ready   (req_if.ready),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
